// ===== hdl/dxtd_pkg.sv =====
`timescale 1ns / 1ps

package dxtd_pkg;

  // Format codes of the block_format register.
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  // Geometry of one block.
  localparam int ROWS = 4;
  localparam int COLS = 4;

  // One compressed block as it arrives.
  typedef struct packed {
    logic [63:0] alpha_half;
    logic [63:0] color_half;
  } in_t;

  // One decoded texel row.
  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] texel_0;
    logic [31:0] texel_1;
    logic [31:0] texel_2;
    logic [31:0] texel_3;
    logic        last_row;
  } out_t;

  // Color and alpha palettes of one block.
  typedef struct packed {
    logic [3:0][31:0] color;
    logic [7:0][7:0]  alpha;
  } pal_t;

endpackage

// ===== hdl/dxtd_palette.sv =====
`timescale 1ns / 1ps

module dxtd_palette (
  input  dxtd_pkg::in_t  block,
  output dxtd_pkg::pal_t pal
);
  import dxtd_pkg::*;

  // Reciprocal constants: exact for every numerator that can occur here.
  localparam logic [10:0] RECIP3 = 11'd683;   // 2^11 / 3, exact below 2048
  localparam logic [11:0] RECIP7 = 12'd2341;  // 2^14 / 7, exact below 5461
  localparam logic [11:0] RECIP5 = 12'd3277;  // 2^14 / 5, exact below 16384

  function automatic logic [23:0] widen565(input logic [15:0] c);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = c[15:11];
    g = c[10:5];
    b = c[4:0];
    return {r, r[4:2], g, g[5:4], b, b[4:2]};
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = x * RECIP3;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = x * RECIP7;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = x * RECIP5;
    return p[21:14];
  endfunction

  logic [15:0] e0;
  logic [15:0] e1;
  logic [23:0] c0;
  logic [23:0] c1;
  logic        four_color;
  logic [7:0]  a0;
  logic [7:0]  a1;
  logic [23:0] mix21;
  logic [23:0] mix12;
  logic [23:0] mid;

  assign e0 = block.color_half[15:0];
  assign e1 = block.color_half[31:16];
  assign c0 = widen565(e0);
  assign c1 = widen565(e1);
  assign four_color = e0 > e1;
  assign a0 = block.alpha_half[7:0];
  assign a1 = block.alpha_half[15:8];

  // Per-channel blends of the two color endpoints.
  always_comb begin
    logic [9:0] s21;
    logic [9:0] s12;
    logic [8:0] s11;
    for (int ch = 0; ch < 3; ch++) begin
      s21 = {1'b0, c0[8*ch +: 8], 1'b0} + {2'b00, c1[8*ch +: 8]};
      s12 = {2'b00, c0[8*ch +: 8]} + {1'b0, c1[8*ch +: 8], 1'b0};
      s11 = {1'b0, c0[8*ch +: 8]} + {1'b0, c1[8*ch +: 8]};
      mix21[8*ch +: 8] = div3(s21);
      mix12[8*ch +: 8] = div3(s12);
      mid[8*ch +: 8]   = s11[8:1];
    end
  end

  always_comb begin
    logic [10:0] num;
    // Color palette: four opaque colors, or three plus transparent black.
    pal.color[0] = {8'hFF, c0};
    pal.color[1] = {8'hFF, c1};
    if (four_color) begin
      pal.color[2] = {8'hFF, mix21};
      pal.color[3] = {8'hFF, mix12};
    end else begin
      pal.color[2] = {8'hFF, mid};
      pal.color[3] = 32'd0;
    end

    // Alpha palette: six rounded sevenths, or four rounded fifths plus 0 and 255.
    pal.alpha[0] = a0;
    pal.alpha[1] = a1;
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++) begin
        num = 11'((6 - i) * a0 + (1 + i) * a1 + 3);
        pal.alpha[i + 2] = div7(num);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        num = 11'((4 - i) * a0 + (1 + i) * a1 + 2);
        pal.alpha[i + 2] = div5(num);
      end
      pal.alpha[6] = 8'h00;
      pal.alpha[7] = 8'hFF;
    end
  end

endmodule

// ===== hdl/dxtd_lane.sv =====
`timescale 1ns / 1ps

module dxtd_lane (
  input  logic [1:0]     fmt,
  input  dxtd_pkg::pal_t pal,
  input  logic [1:0]     color_idx,
  input  logic [3:0]     alpha_nib,
  input  logic [2:0]     alpha_idx,
  output logic [31:0]    texel
);
  import dxtd_pkg::*;

  logic [31:0] color;

  assign color = pal.color[color_idx];

  // Alpha comes from the format: explicit nibble, interpolated, or the color entry.
  always_comb begin
    texel = color;
    case (fmt)
      FMT_DXT3: texel = {alpha_nib, alpha_nib, color[23:0]};
      FMT_DXT5: texel = {pal.alpha[alpha_idx], color[23:0]};
      default:  texel = color;
    endcase
  end

endmodule

// ===== hdl/dxt_block_decoder.sv =====
`timescale 1ns / 1ps

// S3TC block decoder for DXT1, DXT3 and DXT5 4x4 blocks.
// Input: a block is transferred at a rising edge with start high and busy low.
// Configuration: block_format is written on cfg_data when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Write it only while idle.
// Output: each block gives four rows, top first, one per cycle, each shown on
// result for exactly one cycle with result_valid high; last_row marks row 3.
// Order: a block passes from the input register to the row emitter, and each
// row is then registered on result; the four rows follow in consecutive
// cycles.
// Throughput: limited by the single row emitter, which feeds the four texel
// lanes one row per cycle. A block waiting in the input register while the
// emitter works holds busy high.
// Reset: clears all in-flight blocks and sets block_format to DXT1.
// The receiver cannot stall; results are never held back.
module dxt_block_decoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dxtd_pkg::in_t   block,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_data,
  output logic            result_valid,
  output dxtd_pkg::out_t  result
);
  import dxtd_pkg::*;

  logic [1:0]  block_format;

  logic        s1_valid;
  in_t         s1_block;
  pal_t        s1_pal;

  logic        em_valid;
  logic [1:0]  em_row;
  pal_t        em_pal;
  logic [63:0] em_alpha;
  logic [31:0] em_cidx;

  logic        advance;
  logic        accept;

  logic [3:0][7:0]  crow_all;
  logic [3:0][15:0] nib_all;
  logic [3:0][11:0] aidx_all;
  logic [3:0][1:0]  crow;
  logic [3:0][3:0]  nib;
  logic [3:0][2:0]  aidx;
  logic [3:0][31:0] texels;

  // Handshake: the emitter frees up on its last row.
  assign advance   = !em_valid || (em_row == 2'd3);
  assign busy      = s1_valid && !advance;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      block_format <= cfg_data;
    end
  end

  // Input stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_block <= block;
    end
  end

  dxtd_palette u_palette (
    .block (s1_block),
    .pal   (s1_pal)
  );

  // Row emitter: holds one block's palettes and indices while its four rows go out.
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_row   <= 2'd0;
    end else if (advance) begin
      em_valid <= s1_valid;
      em_row   <= 2'd0;
    end else begin
      em_row   <= em_row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      em_pal   <= s1_pal;
      em_alpha <= s1_block.alpha_half;
      em_cidx  <= s1_block.color_half[63:32];
    end
  end

  // Pick the current row's index fields.
  assign crow_all = em_cidx;
  assign nib_all  = em_alpha;
  assign aidx_all = em_alpha[63:16];
  assign crow     = crow_all[em_row];
  assign nib      = nib_all[em_row];
  assign aidx     = aidx_all[em_row];

  // Four texel lanes, one per column.
  for (genvar x = 0; x < COLS; x++) begin : g_lane
    dxtd_lane u_lane (
      .fmt       (block_format),
      .pal       (em_pal),
      .color_idx (crow[x]),
      .alpha_nib (nib[x]),
      .alpha_idx (aidx[x]),
      .texel     (texels[x])
    );
  end

  // Merge the lanes into the registered row result.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= em_valid;
    end
  end

  always_ff @(posedge clk) begin
    result.row_index <= em_row;
    result.texel_0   <= texels[0];
    result.texel_1   <= texels[1];
    result.texel_2   <= texels[2];
    result.texel_3   <= texels[3];
    result.last_row  <= (em_row == 2'd3);
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import dxtd_pkg::*;

  // The format code that the block leaves unused; it decodes as DXT1.
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    STIM_BLOCK,
    STIM_FORMAT,
    STIM_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t  kind;
    in_t         blk;
    logic [1:0]  fmt;
  } stim_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  in_t         block = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = FMT_DXT1;
  logic        result_valid;
  out_t        result;

  stim_t       block_queue[$];
  out_t        expected_rows[$];
  logic [1:0]  fmt_model = FMT_DXT1;
  int          rows_due = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          mismatch_count = 0;

  dxt_block_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .block        (block),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Widen a 565 endpoint to 888 by replicating the top bits.
  function automatic logic [23:0] widen_565(logic [15:0] c);
    logic [7:0] r, g, b;
    r = {c[15:11], c[15:13]};
    g = {c[10:5], c[10:9]};
    b = {c[4:0], c[4:2]};
    return {r, g, b};
  endfunction

  // Per-channel weighted blend, truncated.
  function automatic logic [23:0] blend_888(logic [23:0] a, logic [23:0] b,
                                            int w0, int w1, int d);
    logic [23:0] mixed;
    int          ch;
    for (ch = 0; ch < 3; ch++) begin
      mixed[8*ch +: 8] = 8'((int'(a[8*ch +: 8]) * w0 + int'(b[8*ch +: 8]) * w1) / d);
    end
    return mixed;
  endfunction

  // Expected texel rows of one block under the given format.
  function automatic void decode_block(in_t blk, logic [1:0] fmt);
    logic [15:0]      e0, e1;
    logic [7:0]       a0, a1;
    logic [31:0]      color_pal[4];
    logic [7:0]       alpha_pal[8];
    logic [7:0]       crow;
    logic [31:0]      texel[4];
    logic [3:0]       nib;
    logic [2:0]       aidx;
    out_t             row;
    int               i, y, x;
    e0 = blk.color_half[15:0];
    e1 = blk.color_half[31:16];
    a0 = blk.alpha_half[7:0];
    a1 = blk.alpha_half[15:8];

    // Color palette: four opaque colors, or three plus transparent black.
    color_pal[0] = {8'hFF, widen_565(e0)};
    color_pal[1] = {8'hFF, widen_565(e1)};
    if (e0 > e1) begin
      color_pal[2] = {8'hFF, blend_888(color_pal[0][23:0], color_pal[1][23:0], 2, 1, 3)};
      color_pal[3] = {8'hFF, blend_888(color_pal[0][23:0], color_pal[1][23:0], 1, 2, 3)};
    end else begin
      color_pal[2] = {8'hFF, blend_888(color_pal[0][23:0], color_pal[1][23:0], 1, 1, 2)};
      color_pal[3] = 32'h0;
    end

    // Interpolated alpha palette with rounding.
    alpha_pal[0] = a0;
    alpha_pal[1] = a1;
    if (a0 > a1) begin
      for (i = 0; i < 6; i++) begin
        alpha_pal[i+2] = 8'(((6 - i) * int'(a0) + (1 + i) * int'(a1) + 3) / 7);
      end
    end else begin
      for (i = 0; i < 4; i++) begin
        alpha_pal[i+2] = 8'(((4 - i) * int'(a0) + (1 + i) * int'(a1) + 2) / 5);
      end
      alpha_pal[6] = 8'h00;
      alpha_pal[7] = 8'hFF;
    end

    for (y = 0; y < ROWS; y++) begin
      crow = blk.color_half[32 + 8*y +: 8];
      for (x = 0; x < COLS; x++) begin
        texel[x] = color_pal[crow[2*x +: 2]];
        if (fmt == FMT_DXT3) begin
          nib = blk.alpha_half[16*y + 4*x +: 4];
          texel[x][31:24] = 8'(nib * 17);
        end else if (fmt == FMT_DXT5) begin
          aidx = blk.alpha_half[16 + 3*(4*y + x) +: 3];
          texel[x][31:24] = alpha_pal[aidx];
        end
      end
      row.row_index = 2'(y);
      row.texel_0   = texel[0];
      row.texel_1   = texel[1];
      row.texel_2   = texel[2];
      row.texel_3   = texel[3];
      row.last_row  = (y == ROWS - 1);
      expected_rows.push_back(row);
    end
  endfunction

  task automatic push_block(logic [63:0] alpha_bits, logic [63:0] color_bits);
    stim_t s;
    s.kind = STIM_BLOCK;
    s.blk.alpha_half = alpha_bits;
    s.blk.color_half = color_bits;
    s.fmt = FMT_DXT1;
    block_queue.push_back(s);
  endtask

  task automatic push_marker(stim_kind_t kind, logic [1:0] fmt);
    stim_t s;
    s.kind = kind;
    s.blk = '0;
    s.fmt = fmt;
    block_queue.push_back(s);
  endtask

  // Driver: feeds blocks in bursts, and holds format writes and drains until
  // every row already owed has come out.
  always @(posedge clk) begin : driver
    logic  next_start;
    logic  next_cfg;
    stim_t head;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      fmt_model = FMT_DXT1;
      rows_due = 0;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      if (result_valid) begin
        rows_due--;
      end
      // A block transfer: predict it under the format now in force.
      if (start && !busy) begin
        decode_block(block, fmt_model);
        rows_due += ROWS;
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        fmt_model = cfg_data;
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && block_queue.size() != 0) begin
        head = block_queue[0];
        case (head.kind)
          STIM_BLOCK: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              block <= head.blk;
              next_start = 1'b1;
              void'(block_queue.pop_front());
              if (burst_left > 1) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
              end
            end
          end
          STIM_FORMAT: begin
            if (rows_due == 0) begin
              cfg_data <= head.fmt;
              next_cfg = 1'b1;
              void'(block_queue.pop_front());
            end
          end
          default: begin
            if (rows_due == 0) begin
              void'(block_queue.pop_front());
            end
          end
        endcase
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  // Monitor: each row shown on the result port is checked against the oldest
  // predicted row.
  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst && result_valid) begin
      if (expected_rows.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: unexpected row %0d", $realtime, result.row_index);
        end
        mismatch_count++;
      end else begin
        want = expected_rows.pop_front();
        if (result.row_index !== want.row_index || result.texel_0 !== want.texel_0 ||
            result.texel_1 !== want.texel_1 || result.texel_2 !== want.texel_2 ||
            result.texel_3 !== want.texel_3 || result.last_row !== want.last_row) begin
          if (mismatch_count < 10) begin
            $display("%0t: row mismatch, expected row=%0d %h %h %h %h last=%b",
                     $realtime, want.row_index, want.texel_0, want.texel_1,
                     want.texel_2, want.texel_3, want.last_row);
            $display("%0t:                  got row=%0d %h %h %h %h last=%b",
                     $realtime, result.row_index, result.texel_0, result.texel_1,
                     result.texel_2, result.texel_3, result.last_row);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus: directed blocks under every format code, then random phases.
  initial begin : stimulus
    logic [47:0] ramp;
    logic [63:0] dir_alpha[6];
    logic [63:0] dir_color[6];
    logic [1:0]  dir_fmts[4];
    logic [1:0]  phase_fmts[6];
    logic [63:0] a_bits, c_bits;
    int          f, i, p, pick;

    // Alpha indices counting 0..7 twice across the texels.
    for (i = 0; i < 16; i++) begin
      ramp[3*i +: 3] = 3'(i);
    end
    // All zero: equal color endpoints and equal alpha endpoints.
    dir_alpha[0] = 64'h0;
    dir_color[0] = 64'h0;
    // All ones.
    dir_alpha[1] = '1;
    dir_color[1] = '1;
    // Four-color mode, eight-entry alpha palette, every index used.
    dir_alpha[2] = {ramp, 8'h00, 8'hFF};
    dir_color[2] = {32'hE4E4_E4E4, 16'h0000, 16'hFFFF};
    // Three-color mode with transparent black, six-entry alpha palette.
    dir_alpha[3] = {ramp, 8'hFF, 8'h00};
    dir_color[3] = {32'hE4E4_E4E4, 16'hFFFF, 16'h0000};
    // Alpha endpoints one apart; pure red and pure green color endpoints.
    dir_alpha[4] = {ramp, 8'h7F, 8'h80};
    dir_color[4] = {32'h1B1B_1B1B, 16'h07E0, 16'hF800};
    // Explicit alpha nibbles 0..15, every texel on the black entry.
    dir_alpha[5] = 64'hFEDC_BA98_7654_3210;
    dir_color[5] = {32'hFFFF_FFFF, 16'h001F, 16'h001F};

    dir_fmts = '{FMT_DXT1, FMT_DXT3, FMT_DXT5, FMT_UNUSED};
    for (f = 0; f < 4; f++) begin
      push_marker(STIM_FORMAT, dir_fmts[f]);
      for (i = 0; i < 6; i++) begin
        push_block(dir_alpha[i], dir_color[i]);
      end
    end

    // Random phases, each with its own format and a full drain midway.
    phase_fmts = '{FMT_DXT5, FMT_DXT3, FMT_DXT1, FMT_UNUSED, FMT_DXT3, FMT_DXT5};
    for (p = 0; p < 6; p++) begin
      push_marker(STIM_FORMAT, phase_fmts[p]);
      for (i = 0; i < 75; i++) begin
        if (i == 37) begin
          push_marker(STIM_DRAIN, FMT_DXT1);
        end
        a_bits = {$urandom, $urandom};
        c_bits = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          c_bits[31:16] = c_bits[15:0];
        end
        if (pick == 2 || pick == 3) begin
          a_bits[15:8] = a_bits[7:0];
        end else if (pick == 4) begin
          a_bits[15:8] = a_bits[7:0] + 8'($urandom_range(0, 2)) - 8'd1;
        end
        push_block(a_bits, c_bits);
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
    end while (block_queue.size() != 0 || start || cfg_valid || expected_rows.size() != 0);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && expected_rows.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/dxtd_pkg.sv
hdl/dxtd_palette.sv
hdl/dxtd_lane.sv
hdl/dxt_block_decoder.sv
tb/testbench.sv
